// ----- sv/edr_pkg.sv -----
// Shared constants and types for the encoder delta and rpm block.
// No dependencies; used by edr_div and encoder_delta_and_rpm.
`default_nettype none

package edr_pkg;

    // Shared divider operand widths
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 40;
    localparam int DIV_STEPS  = DIVIDEND_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Scale from counts per ms to counts per minute
    localparam logic [15:0] RPM_SCALE = 16'd60000;

    // Configuration register widths and reset values
    localparam int GEAR_W   = 8;
    localparam int CPT_W    = 13;
    localparam int PRESET_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [GEAR_W-1:0]   GEAR_RESET   = 8'd50;
    localparam logic [CPT_W-1:0]    CPT_RESET    = 13'd64;
    localparam logic [PRESET_W-1:0] PRESET_RESET = 16'd32000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESET = 2'd2;

    // Field widths
    localparam int COUNT_W = 16;
    localparam int TIME_W  = 32;
    localparam int DELTA_W = 17;
    localparam int RPM_W   = 16;
    localparam int TOTAL_W = 32;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 136;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_D1GO = 7'b0000100,
        S_D1   = 7'b0001000,
        S_D2GO = 7'b0010000,
        S_D2   = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ----- sv/encoder_delta_and_rpm.sv -----
// Top level: two-encoder tick delta, running totals and rpm measurement.
// Depends on edr_pkg and edr_div (shared serial divider).
//
//  channel   | dir | handshake             | payload (lowest bit first)
//  ----------+-----+-----------------------+-----------------------------------------
//  s stream  | in  | i_s_tvalid/o_s_tready | tdata: count_one, count_two, now_ms
//  m stream  | out | o_m_tvalid/i_m_tready | tdata: delta_one, delta_two, rpm_one,
//            |     |                       |   rpm_two, total_one, total_two; tuser: zero_interval
//  cfg write | in  | i_cfg_we              | i_cfg_idx selects gear/cpt/preset
//
// Each beat runs from acceptance in the idle state through four passes of the
// shared divider (start, 32 steps, done), with one product step per encoder,
// and ends when the result is loaded in the output state. Each encoder takes
// two passes: delta times 60000 over counts_per_turn, then over interval times
// the gearbox reduction.
// A zero interval skips the divider and goes from the product step to output.
// Reset is synchronous, active low: clears totals and last time, restores config.
// A finished result waits in the output register; the next beat is taken
// while it waits, and only the final hand-off stalls on i_m_tready.
`default_nettype none

module encoder_delta_and_rpm #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // count_one [15:0], count_two [31:16], now_ms [63:32]
    input  wire logic [edr_pkg::S_DATA_W-1:0]       i_s_tdata,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // delta_one [16:0], delta_two [33:17], rpm_one [49:34], rpm_two [65:50],
    // total_one [97:66], total_two [129:98], zero fill [135:130]
    output logic [edr_pkg::M_DATA_W-1:0]            o_m_tdata,
    // zero_interval [0]
    output logic                                    o_m_tuser,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    input  wire logic                               i_cfg_we,
    input  wire logic [edr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [edr_pkg::CFG_W-1:0]          i_cfg_data
);

    // Only the low COUNTER_WIDTH bits of counts and preset take part
    localparam logic [edr_pkg::COUNT_W-1:0] CNT_MASK =
        (COUNTER_WIDTH >= edr_pkg::COUNT_W) ? {edr_pkg::COUNT_W{1'b1}}
        : edr_pkg::COUNT_W'((33'd1 << COUNTER_WIDTH) - 33'd1);

    edr_pkg::t_state r_state, n_state;

    logic [edr_pkg::GEAR_W-1:0]     r_gear;
    logic [edr_pkg::CPT_W-1:0]      r_cpt;
    logic [edr_pkg::PRESET_W-1:0]   r_preset;

    logic [edr_pkg::TIME_W-1:0]     r_last_time;
    logic [edr_pkg::TOTAL_W-1:0]    r_sum_one;
    logic [edr_pkg::TOTAL_W-1:0]    r_sum_two;

    logic [edr_pkg::DELTA_W-1:0]    r_delta [2];
    logic [edr_pkg::RPM_W-1:0]      r_rpm [2];
    logic [edr_pkg::TIME_W-1:0]     r_interval;
    logic                           r_zero;
    logic                           r_enc;
    logic [edr_pkg::DIVIDEND_W-1:0] r_num;
    logic [edr_pkg::DIVISOR_W-1:0]  r_den;

    logic                           r_m_valid;
    logic [edr_pkg::M_DATA_W-1:0]   r_m_data;
    logic                           r_m_user;

    logic [edr_pkg::COUNT_W-1:0]    w_count_one;
    logic [edr_pkg::COUNT_W-1:0]    w_count_two;
    logic [edr_pkg::TIME_W-1:0]     w_now;
    logic [edr_pkg::DELTA_W-1:0]    w_d_one;
    logic [edr_pkg::DELTA_W-1:0]    w_d_two;
    logic [edr_pkg::DELTA_W-1:0]    w_preset_ext;
    logic [edr_pkg::GEAR_W-1:0]     w_gear;
    logic [edr_pkg::CPT_W-1:0]      w_cpt;
    logic [edr_pkg::DELTA_W-1:0]    w_dsel;
    logic [edr_pkg::COUNT_W-1:0]    w_mag;
    logic                           w_accept;
    logic                           w_load_out;
    logic [edr_pkg::RPM_W-1:0]      w_sat;

    logic                           w_div_start;
    logic [edr_pkg::DIVIDEND_W-1:0] w_div_dividend;
    logic [edr_pkg::DIVISOR_W-1:0]  w_div_divisor;
    logic                           w_div_done;
    logic [edr_pkg::DIVIDEND_W-1:0] w_quo;

    assign w_count_one = i_s_tdata[15:0] & CNT_MASK;
    assign w_count_two = i_s_tdata[31:16] & CNT_MASK;
    assign w_now       = i_s_tdata[63:32];

    // Delta is count minus preset, both masked, as a 17-bit signed value
    assign w_preset_ext = {1'b0, r_preset & CNT_MASK};
    assign w_d_one = {1'b0, w_count_one} - w_preset_ext;
    assign w_d_two = {1'b0, w_count_two} - w_preset_ext;

    // A zero register acts as one
    assign w_gear = (r_gear == '0) ? edr_pkg::GEAR_W'(1) : r_gear;
    assign w_cpt  = (r_cpt == '0) ? edr_pkg::CPT_W'(1) : r_cpt;

    // Work on magnitudes; both divisions truncate toward zero
    assign w_dsel = r_delta[r_enc];
    assign w_mag  = w_dsel[edr_pkg::DELTA_W-1]
                  ? edr_pkg::COUNT_W'(edr_pkg::DELTA_W'(0) - w_dsel)
                  : w_dsel[edr_pkg::COUNT_W-1:0];

    // Restore the sign and clamp to the 16-bit range
    always_comb begin
        if (w_dsel[edr_pkg::DELTA_W-1]) begin
            w_sat = (w_quo > 32'd32768) ? 16'h8000 : edr_pkg::RPM_W'(32'd0 - w_quo);
        end else begin
            w_sat = (w_quo > 32'd32767) ? 16'h7FFF : w_quo[edr_pkg::RPM_W-1:0];
        end
    end

    assign w_accept   = i_s_tvalid && (r_state == edr_pkg::S_IDLE);
    assign w_load_out = (r_state == edr_pkg::S_OUT) && (!r_m_valid || i_m_tready);

    // Divider operand select: first pass over counts_per_turn, second over
    // interval times gear ratio
    assign w_div_start    = (r_state == edr_pkg::S_D1GO) || (r_state == edr_pkg::S_D2GO);
    assign w_div_dividend = (r_state == edr_pkg::S_D1GO) ? r_num : w_quo;
    assign w_div_divisor  = (r_state == edr_pkg::S_D1GO)
                          ? edr_pkg::DIVISOR_W'(w_cpt) : r_den;

    edr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edr_pkg::S_IDLE: if (i_s_tvalid) n_state = edr_pkg::S_MUL;
            edr_pkg::S_MUL:  n_state = r_zero ? edr_pkg::S_OUT : edr_pkg::S_D1GO;
            edr_pkg::S_D1GO: n_state = edr_pkg::S_D1;
            edr_pkg::S_D1:   if (w_div_done) n_state = edr_pkg::S_D2GO;
            edr_pkg::S_D2GO: n_state = edr_pkg::S_D2;
            edr_pkg::S_D2: begin
                if (w_div_done) n_state = r_enc ? edr_pkg::S_OUT : edr_pkg::S_MUL;
            end
            edr_pkg::S_OUT:  if (w_load_out) n_state = edr_pkg::S_IDLE;
            default:         n_state = edr_pkg::S_IDLE;
        endcase
    end

    // Control state, config and running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= edr_pkg::S_IDLE;
            r_gear      <= edr_pkg::GEAR_RESET;
            r_cpt       <= edr_pkg::CPT_RESET;
            r_preset    <= edr_pkg::PRESET_RESET;
            r_last_time <= '0;
            r_sum_one   <= '0;
            r_sum_two   <= '0;
            r_m_valid   <= 1'b0;
            r_enc       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    edr_pkg::CFG_GEAR:   r_gear   <= i_cfg_data[edr_pkg::GEAR_W-1:0];
                    edr_pkg::CFG_CPT:    r_cpt    <= i_cfg_data[edr_pkg::CPT_W-1:0];
                    edr_pkg::CFG_PRESET: r_preset <= i_cfg_data[edr_pkg::PRESET_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_last_time <= w_now;
                r_sum_one   <= r_sum_one + edr_pkg::TOTAL_W'(signed'(w_d_one));
                r_sum_two   <= r_sum_two + edr_pkg::TOTAL_W'(signed'(w_d_two));
                r_enc       <= 1'b0;
            end else if (r_state == edr_pkg::S_D2 && w_div_done) begin
                r_enc <= 1'b1;
            end
            // Hold the result until taken, then drop valid unless reloaded
            if (w_load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_delta[0] <= w_d_one;
            r_delta[1] <= w_d_two;
            r_interval <= w_now - r_last_time;
            r_zero     <= (w_now == r_last_time);
        end
        if (r_state == edr_pkg::S_MUL) begin
            r_num <= edr_pkg::DIVIDEND_W'(w_mag) * edr_pkg::DIVIDEND_W'(edr_pkg::RPM_SCALE);
            r_den <= edr_pkg::DIVISOR_W'(r_interval) * edr_pkg::DIVISOR_W'(w_gear);
            if (r_zero) begin
                r_rpm[0] <= '0;
                r_rpm[1] <= '0;
            end
        end
        if (r_state == edr_pkg::S_D2 && w_div_done) begin
            r_rpm[r_enc] <= w_sat;
        end
        if (w_load_out) begin
            r_m_data <= {6'd0, r_sum_two, r_sum_one, r_rpm[1], r_rpm[0],
                         r_delta[1], r_delta[0]};
            r_m_user <= r_zero;
        end
    end

    assign o_s_tready = (r_state == edr_pkg::S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

`default_nettype wire

// ----- sv/edr_div.sv -----
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on edr_pkg for operand widths.
`default_nettype none

module edr_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [edr_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  wire logic [edr_pkg::DIVISOR_W-1:0]     i_divisor,
    output logic                                   o_done,
    output logic [edr_pkg::DIVIDEND_W-1:0]         o_quotient
);

    logic                                r_busy;
    logic                                r_done;
    logic [edr_pkg::DIV_CNT_W-1:0]       r_cnt;
    logic [edr_pkg::DIVISOR_W-1:0]       r_rem;
    logic [edr_pkg::DIVIDEND_W-1:0]      r_quo;
    logic [edr_pkg::DIVISOR_W-1:0]       r_dvs;

    logic [edr_pkg::DIVISOR_W:0]         w_trial;
    logic                                w_ge;
    logic [edr_pkg::DIVISOR_W:0]         w_diff;

    // Shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[edr_pkg::DIVIDEND_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == edr_pkg::DIV_CNT_W'(edr_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[edr_pkg::DIVISOR_W-1:0]
                          : w_trial[edr_pkg::DIVISOR_W-1:0];
            r_quo <= {r_quo[edr_pkg::DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- test/encoder_delta_and_rpm_test.sv -----
// Self-checking testbench for encoder_delta_and_rpm: stream stimulus, reply checks.
// Depends on edr_pkg and the encoder_delta_and_rpm RTL; a built-in speed predictor
// derives every expected reading.

module encoder_delta_and_rpm_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    // Slowest beat is four full divider passes plus short stalls; allow many times that
    localparam int IDLE_LIMIT      = 2000;
    // Drain time after the last reading: one full divider sequence and some margin
    localparam int TAIL_CYCLES     = 160;
    localparam int CFG_SETTLE      = 4;
    localparam int MAX_WAIT        = 5;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 57;

    localparam longint RPM_PER_MS = edr_pkg::RPM_SCALE;
    localparam longint RPM_MAX    = 32767;
    localparam longint RPM_MIN    = -32768;

    // Index that selects no register; a write to it must change nothing
    localparam logic [edr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Input beat, first field in the lowest bits
    typedef struct packed {
        logic [edr_pkg::TIME_W-1:0]  now_ms;
        logic [edr_pkg::COUNT_W-1:0] count_two;
        logic [edr_pkg::COUNT_W-1:0] count_one;
    } t_sample;

    typedef struct {
        logic [edr_pkg::DELTA_W-1:0] delta_one;
        logic [edr_pkg::DELTA_W-1:0] delta_two;
        logic [edr_pkg::RPM_W-1:0]   rpm_one;
        logic [edr_pkg::RPM_W-1:0]   rpm_two;
        logic [edr_pkg::TOTAL_W-1:0] total_one;
        logic [edr_pkg::TOTAL_W-1:0] total_two;
        logic                        zero_interval;
    } t_reading;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic [edr_pkg::S_DATA_W-1:0]      i_s_tdata;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [edr_pkg::M_DATA_W-1:0]      o_m_tdata;
    logic                              o_m_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic                              i_cfg_we;
    logic [edr_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [edr_pkg::CFG_W-1:0]         i_cfg_data;

    // Predictor copy of the registers and the running state
    logic [edr_pkg::GEAR_W-1:0]   gear_q;
    logic [edr_pkg::CPT_W-1:0]    cpt_q;
    logic [edr_pkg::PRESET_W-1:0] preset_q;
    logic [edr_pkg::TIME_W-1:0]   prev_time;
    logic [edr_pkg::TOTAL_W-1:0]  total_one_q;
    logic [edr_pkg::TOTAL_W-1:0]  total_two_q;

    t_sample  samples_pending[$];
    t_reading expected_readings[$];

    int samples_queued   = 0;
    int samples_taken    = 0;
    int readings_checked = 0;
    int zero_spans       = 0;
    int cfg_writes       = 0;
    int error_count      = 0;
    int idle_cycles      = 0;

    // Handshake flags of the last rising edge, read by the falling-edge driver
    logic s_taken = 1'b0;
    logic m_taken = 1'b0;

    int   send_wait  = 0;
    int   recv_wait  = 0;
    logic send_burst = 1'b0;
    logic recv_burst = 1'b0;

    encoder_delta_and_rpm u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Speed from one delta: scale to counts per minute over counts per turn, then
    // divide by interval times gear ratio; both steps truncate toward zero
    function automatic logic [edr_pkg::RPM_W-1:0] speed_rpm(longint delta, longint cpt,
                                                            longint span);
        longint q;
        q = (delta * RPM_PER_MS) / cpt;
        q = q / span;
        if (q > RPM_MAX) q = RPM_MAX;
        else if (q < RPM_MIN) q = RPM_MIN;
        return q[edr_pkg::RPM_W-1:0];
    endfunction

    // Advance the predictor by one sample and return the reading it must produce
    function automatic t_reading predict_reading(t_sample s);
        longint d1, d2, gear, cpt, span;
        logic [edr_pkg::TIME_W-1:0] interval;
        t_reading r;
        d1       = longint'(s.count_one) - longint'(preset_q);
        d2       = longint'(s.count_two) - longint'(preset_q);
        interval = s.now_ms - prev_time;
        // A zero register acts as one
        gear     = (gear_q == '0) ? 64'sd1 : longint'(gear_q);
        cpt      = (cpt_q == '0) ? 64'sd1 : longint'(cpt_q);
        span     = longint'(interval) * gear;

        prev_time   = s.now_ms;
        total_one_q = total_one_q + d1[edr_pkg::TOTAL_W-1:0];
        total_two_q = total_two_q + d2[edr_pkg::TOTAL_W-1:0];

        r.delta_one     = d1[edr_pkg::DELTA_W-1:0];
        r.delta_two     = d2[edr_pkg::DELTA_W-1:0];
        r.zero_interval = (interval == '0);
        // Zero interval: force speed to zero instead of dividing
        r.rpm_one       = r.zero_interval ? '0 : speed_rpm(d1, cpt, span);
        r.rpm_two       = r.zero_interval ? '0 : speed_rpm(d2, cpt, span);
        r.total_one     = total_one_q;
        r.total_two     = total_two_q;
        if (r.zero_interval) zero_spans++;
        return r;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Rising edge: track registers, predict accepted samples, check readings
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        s_taken <= i_s_tvalid && o_s_tready;
        m_taken <= o_m_tvalid && i_m_tready;
        if (!i_rst_n) begin
            gear_q      = edr_pkg::GEAR_RESET;
            cpt_q       = edr_pkg::CPT_RESET;
            preset_q    = edr_pkg::PRESET_RESET;
            prev_time   = '0;
            total_one_q = '0;
            total_two_q = '0;
        end else begin
            if (i_cfg_we) begin
                cfg_writes++;
                case (i_cfg_idx)
                    edr_pkg::CFG_GEAR:   gear_q   = i_cfg_data[edr_pkg::GEAR_W-1:0];
                    edr_pkg::CFG_CPT:    cpt_q    = i_cfg_data[edr_pkg::CPT_W-1:0];
                    edr_pkg::CFG_PRESET: preset_q = i_cfg_data[edr_pkg::PRESET_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_readings.push_back(predict_reading(i_s_tdata));
                samples_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.delta_one     = o_m_tdata[16:0];
                got.delta_two     = o_m_tdata[33:17];
                got.rpm_one       = o_m_tdata[49:34];
                got.rpm_two       = o_m_tdata[65:50];
                got.total_one     = o_m_tdata[97:66];
                got.total_two     = o_m_tdata[129:98];
                got.zero_interval = o_m_tuser;
                if (expected_readings.size() == 0) begin
                    $error("reading beat with no sample waiting for it");
                    error_count++;
                end else begin
                    want = expected_readings.pop_front();
                    readings_checked++;
                    compare_field("delta_one", $signed(want.delta_one), $signed(got.delta_one));
                    compare_field("delta_two", $signed(want.delta_two), $signed(got.delta_two));
                    compare_field("rpm_one", $signed(want.rpm_one), $signed(got.rpm_one));
                    compare_field("rpm_two", $signed(want.rpm_two), $signed(got.rpm_two));
                    compare_field("total_one", $signed(want.total_one), $signed(got.total_one));
                    compare_field("total_two", $signed(want.total_two), $signed(got.total_two));
                    compare_field("zero_interval", want.zero_interval, got.zero_interval);
                end
            end
        end
    end

    // Falling edge: drive the sample stream and the reading back-pressure
    always @(negedge i_clk) begin
        logic vld;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            // Drop valid once the beat went through, then hold off for the drawn gap
            vld = i_s_tvalid && !s_taken;
            if (!vld) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (samples_pending.size() > 0) begin
                    i_s_tdata <= samples_pending.pop_front();
                    vld = 1'b1;
                    // Flip between gap-free bursts and random gaps now and then
                    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
                    send_wait = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
                end
            end
            i_s_tvalid <= vld;

            // Draw a fresh stall per reading; count it down only while a reading waits
            if (m_taken) begin
                if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            i_m_tready <= (recv_wait == 0);
            if (recv_wait > 0 && o_m_tvalid) recv_wait--;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_sample(logic [15:0] c1, logic [15:0] c2, logic [31:0] now);
        t_sample s;
        s.count_one = c1;
        s.count_two = c2;
        s.now_ms    = now;
        samples_pending.push_back(s);
        samples_queued++;
    endtask

    // Hold the sender until every queued sample has come back as a reading
    task automatic settle();
        wait (samples_taken == samples_queued && expected_readings.size() == 0);
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [edr_pkg::CFG_IDX_W-1:0] idx, logic [edr_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [15:0] preset;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [31:0] now;
        int          spread;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = edr_pkg::CFG_GEAR;
        i_cfg_data = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: preset 32000, 64 counts per turn, gear 50
        queue_sample(16'd32000, 16'd32000, 32'd0);           // zero interval right after reset
        queue_sample(16'd0, 16'hFFFF, 32'd1);                // count extremes, both speeds saturate
        queue_sample(16'hFFFF, 16'd0, 32'd1);                // zero interval with nonzero deltas
        queue_sample(16'd32010, 16'd31990, 32'd3);           // small speeds of either sign
        queue_sample(16'd32001, 16'd31999, 32'hFFFF_FFFF);   // huge interval, speeds truncate to 0
        queue_sample(16'd32100, 16'd31900, 32'd0);           // time wraps, interval of one
        queue_sample(16'h5555, 16'hAAAA, 32'hAAAA_AAAA);
        queue_sample(16'hAAAA, 16'h5555, 32'h5555_5555);
        settle();

        // Low extremes: zero gear and zero counts per turn act as one, preset zero
        cfg_write(edr_pkg::CFG_GEAR, 16'd0);
        cfg_write(edr_pkg::CFG_CPT, 16'd0);
        cfg_write(edr_pkg::CFG_PRESET, 16'd0);
        cfg_write(CFG_SPARE, 16'hFFFF);
        queue_sample(16'hFFFF, 16'd0, 32'h5555_5556);
        queue_sample(16'd1, 16'hFFFF, 32'h5555_5556);
        queue_sample(16'd1, 16'd2, 32'h5555_5555);
        queue_sample(16'd100, 16'd7, 32'h5555_5600);
        settle();

        // High extremes: widest gear and counts per turn, preset at the top
        cfg_write(edr_pkg::CFG_GEAR, 16'hFFFF);
        cfg_write(edr_pkg::CFG_CPT, 16'hFFFF);
        cfg_write(edr_pkg::CFG_PRESET, 16'hFFFF);
        queue_sample(16'd0, 16'hFFFF, 32'h5555_5601);
        queue_sample(16'hFFFE, 16'd0, 32'h5555_5601);
        queue_sample(16'd0, 16'd0, 32'h0000_0000);
        queue_sample(16'h8000, 16'h7FFF, 32'h0000_0002);
        settle();

        // Realistic setting: one turn in 1024 counts, gear 1
        cfg_write(edr_pkg::CFG_GEAR, 16'd1);
        cfg_write(edr_pkg::CFG_CPT, 16'd1024);
        cfg_write(edr_pkg::CFG_PRESET, 16'd32000);
        preset = 16'd32000;
        now    = 32'd10;

        // Random phases: settings may change each phase, samples near the preset mostly
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            if ($urandom_range(0, 3) != 0) cfg_write(edr_pkg::CFG_GEAR, 16'($urandom()));
            if ($urandom_range(0, 3) != 0) begin
                cfg_write(edr_pkg::CFG_CPT, $urandom_range(0, 1) ? 16'($urandom())
                                                                : 16'($urandom_range(1, 1024)));
            end
            if ($urandom_range(0, 3) != 0) begin
                preset = 16'($urandom());
                cfg_write(edr_pkg::CFG_PRESET, preset);
            end
            spread = $urandom_range(1, 4000);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 15))
                    0:       ;                           // repeat the time: zero interval
                    1:       now = $urandom();           // jump anywhere, wrap included
                    default: now = now + $urandom_range(1, 40);
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    c1 = 16'($urandom());
                    c2 = 16'($urandom());
                end else begin
                    c1 = preset + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                    c2 = preset + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
                end
                queue_sample(c1, c2, now);
            end
        end

        // Drain, then give the block one more full sequence to show any stray beat
        wait (samples_taken == samples_queued && expected_readings.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            $error("%0d readings never arrived", expected_readings.size());
            error_count++;
        end

        $display("Run covered %0d samples and %0d checked readings (%0d with zero interval),",
                 samples_taken, readings_checked, zero_spans);
        $display("across %0d register writes including both extremes of every register.",
                 cfg_writes);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
